@@ hdl/lruc_pkg.sv @@
package lruc_pkg;

  localparam int NUM_SETS = 16;
  localparam int WAYS = 4;
  localparam int WORDS_PER_BLOCK = 4;
  localparam int BYTES_PER_WORD = 4;

  localparam int OFS_BITS = $clog2(WORDS_PER_BLOCK * BYTES_PER_WORD);
  localparam int IDX_BITS = $clog2(NUM_SETS);
  localparam int WAY_BITS = $clog2(WAYS);
  localparam int TAG_BITS = 32 - OFS_BITS - IDX_BITS;
  localparam int ENTRIES = NUM_SETS * WAYS;
  localparam int ENT_BITS = IDX_BITS + WAY_BITS;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] REG_ADDRESS_BITS = 2'd0;
  localparam logic [1:0] REG_HIT_CYCLES = 2'd1;
  localparam logic [1:0] REG_FILL_CYCLES = 2'd2;
  localparam logic [1:0] REG_WRITEBACK_CYCLES = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [3:0] set_index;
    logic [1:0] way_used;
    logic fill_needed;
    logic [31:0] fill_address;
    logic writeback_needed;
    logic [31:0] writeback_address;
    logic [15:0] elapsed;
    logic last;
  } rsp_t;

endpackage

@@ hdl/lruc_ram.sv @@
module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input logic clk,
  input logic we,
  input logic [$clog2(DEPTH)-1:0] waddr,
  input logic [WIDTH-1:0] wdata,
  input logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/lru_write_back_cache_controller.sv @@
// Tag and LRU policy controller of a 16-set, 4-way, write-allocate, write-back
// cache with 16-byte blocks. Requests are taken one at a time; in_ready is high
// only while the controller is idle. The tags sit in a single-port-read memory
// that one comparator scans a way at a time: each way probed is read (S_RD) and
// then compared (S_CMP), and a hit goes straight to S_FIN to post the response;
// a miss probes all 4 ways and then reads the victim tag (S_VRD, S_VCHK).
// The controller goes back to idle on the edge that posts the response, and a
// stalled response output holds it. A flush walks all 64 entries (S_FRD, S_FCHK)
// and posts one response per dirty block, the last marked with last, or a
// single empty response with last set if no block is dirty. Operation
// code 3 is accepted and dropped. Configuration is written through cfg_we,
// cfg_index and cfg_data and takes effect at once.
module lru_write_back_cache_controller (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input lruc_pkg::req_t in_data,
  output logic out_valid,
  input logic out_ready,
  output lruc_pkg::rsp_t out_data,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [9:0] cfg_data
);

  localparam int SB = 4;
  localparam logic [SB-1:0] S_IDLE = 4'd0;
  localparam logic [SB-1:0] S_RD = 4'd1;
  localparam logic [SB-1:0] S_CMP = 4'd2;
  localparam logic [SB-1:0] S_VRD = 4'd3;
  localparam logic [SB-1:0] S_VCHK = 4'd4;
  localparam logic [SB-1:0] S_FIN = 4'd5;
  localparam logic [SB-1:0] S_FRD = 4'd6;
  localparam logic [SB-1:0] S_FCHK = 4'd7;
  localparam logic [SB-1:0] S_FEND = 4'd8;

  localparam int OB = lruc_pkg::OFS_BITS;
  localparam int IB = lruc_pkg::IDX_BITS;
  localparam int WB = lruc_pkg::WAY_BITS;
  localparam int TB = lruc_pkg::TAG_BITS;
  localparam int EB = lruc_pkg::ENT_BITS;
  localparam int NE = lruc_pkg::ENTRIES;
  localparam int ORD_BITS = lruc_pkg::WAYS * WB;

  function automatic logic [ORD_BITS-1:0] reset_order();
    logic [ORD_BITS-1:0] o;
    o = '0;
    for (int i = 0; i < lruc_pkg::WAYS; i++) begin
      o[i*WB +: WB] = WB'(i);
    end
    return o;
  endfunction

  function automatic logic [ORD_BITS-1:0] touch(logic [ORD_BITS-1:0] o, logic [WB-1:0] w);
    logic [ORD_BITS-1:0] r;
    logic seen;
    r = o;
    seen = 1'b0;
    for (int i = 0; i < lruc_pkg::WAYS - 1; i++) begin
      if (o[i*WB +: WB] == w) begin
        seen = 1'b1;
      end
      if (seen) begin
        r[i*WB +: WB] = o[(i+1)*WB +: WB];
      end
    end
    r[(lruc_pkg::WAYS-1)*WB +: WB] = w;
    return r;
  endfunction

  logic [SB-1:0] state;
  logic [5:0] address_bits;
  logic [9:0] hit_cycles;
  logic [9:0] fill_cycles;
  logic [9:0] writeback_cycles;

  logic [NE-1:0] valid;
  logic [NE-1:0] dirty;
  logic [ORD_BITS-1:0] order [lruc_pkg::NUM_SETS];

  logic write_op;
  logic [31:0] addr;
  logic [IB-1:0] set;
  logic [TB-1:0] tag;
  logic [WB-1:0] cnt;
  logic [WB-1:0] way;
  logic hit;
  logic wneed;
  logic [TB-1:0] vtag;
  logic [EB-1:0] fidx;
  logic [15:0] ftime;

  logic pend_v;
  lruc_pkg::rsp_t pend;

  logic ram_we;
  logic [EB-1:0] ram_raddr;
  logic [TB-1:0] ram_rdata;
  logic out_free;
  logic post;
  logic [31:0] masked;
  logic [16:0] fsum;
  logic [11:0] atime;
  lruc_pkg::rsp_t acc_rsp;
  lruc_pkg::rsp_t flush_rsp;
  lruc_pkg::rsp_t empty_rsp;
  lruc_pkg::rsp_t pend_end;
  logic fdirty;

  lruc_ram #(
    .WIDTH(TB),
    .DEPTH(NE)
  ) u_tags (
    .clk(clk),
    .we(ram_we),
    .waddr({set, way}),
    .wdata(tag),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign masked = in_data.address & ~(32'hFFFF_FFFF << address_bits);
  assign ram_we = (state == S_VCHK);
  assign fdirty = valid[fidx] && dirty[fidx];
  assign fsum = {1'b0, ftime} + 17'(writeback_cycles);
  assign post = out_free && ((state == S_FIN) || (state == S_FEND) ||
                             (state == S_FCHK && fdirty && pend_v));

  always_comb begin
    unique case (state) inside
      S_FRD, S_FCHK, S_FEND: ram_raddr = fidx;
      S_VRD, S_VCHK, S_FIN: ram_raddr = {set, way};
      default: ram_raddr = {set, cnt};
    endcase
  end

  always_comb begin
    atime = 12'(hit_cycles);
    if (!hit) begin
      atime = atime + 12'(fill_cycles) + (wneed ? 12'(writeback_cycles) : 12'd0);
    end
    acc_rsp = '0;
    acc_rsp.hit = hit;
    acc_rsp.set_index = 4'(set);
    acc_rsp.way_used = 2'(way);
    acc_rsp.fill_needed = !hit;
    acc_rsp.fill_address = hit ? 32'd0 : {addr[31:OB], {OB{1'b0}}};
    acc_rsp.writeback_needed = wneed;
    acc_rsp.writeback_address = wneed ? {vtag, set, {OB{1'b0}}} : 32'd0;
    acc_rsp.elapsed = 16'(atime);
    acc_rsp.last = 1'b1;

    flush_rsp = '0;
    flush_rsp.set_index = 4'(fidx[EB-1:WB]);
    flush_rsp.way_used = 2'(fidx[WB-1:0]);
    flush_rsp.writeback_needed = 1'b1;
    flush_rsp.writeback_address = {ram_rdata, fidx[EB-1:WB], {OB{1'b0}}};
    flush_rsp.elapsed = fsum[16] ? 16'hFFFF : fsum[15:0];

    empty_rsp = '0;
    empty_rsp.last = 1'b1;

    pend_end = pend;
    pend_end.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      address_bits <= 6'd32;
      hit_cycles <= 10'd1;
      fill_cycles <= 10'd10;
      writeback_cycles <= 10'd10;
      valid <= '0;
      dirty <= '0;
      for (int s = 0; s < lruc_pkg::NUM_SETS; s++) begin
        order[s] <= reset_order();
      end
      out_valid <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lruc_pkg::REG_ADDRESS_BITS: address_bits <= cfg_data[5:0];
          lruc_pkg::REG_HIT_CYCLES: hit_cycles <= cfg_data;
          lruc_pkg::REG_FILL_CYCLES: fill_cycles <= cfg_data;
          lruc_pkg::REG_WRITEBACK_CYCLES: writeback_cycles <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && !post) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            write_op <= (in_data.operation == lruc_pkg::OP_WRITE);
            addr <= masked;
            set <= masked[OB +: IB];
            tag <= masked[31 -: TB];
            cnt <= '0;
            fidx <= '0;
            ftime <= '0;
            if (in_data.operation == lruc_pkg::OP_FLUSH) begin
              state <= S_FRD;
            end else if (in_data.operation == lruc_pkg::OP_READ ||
                         in_data.operation == lruc_pkg::OP_WRITE) begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (valid[{set, cnt}] && ram_rdata == tag) begin
            hit <= 1'b1;
            wneed <= 1'b0;
            way <= cnt;
            state <= S_FIN;
          end else if (cnt == WB'(lruc_pkg::WAYS - 1)) begin
            hit <= 1'b0;
            way <= order[set][WB-1:0];
            state <= S_VRD;
          end else begin
            cnt <= cnt + 1'b1;
            state <= S_RD;
          end
        end
        S_VRD: state <= S_VCHK;
        S_VCHK: begin
          vtag <= ram_rdata;
          wneed <= valid[{set, way}] && dirty[{set, way}];
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data <= acc_rsp;
            valid[{set, way}] <= 1'b1;
            dirty[{set, way}] <= write_op || (hit && dirty[{set, way}]);
            order[set] <= touch(order[set], way);
            state <= S_IDLE;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (!fdirty) begin
            state <= (fidx == EB'(NE - 1)) ? S_FEND : S_FRD;
            fidx <= fidx + 1'b1;
          end else if (!pend_v || out_free) begin
            if (pend_v) begin
              out_valid <= 1'b1;
              out_data <= pend;
            end
            pend_v <= 1'b1;
            pend <= flush_rsp;
            ftime <= flush_rsp.elapsed;
            dirty[fidx] <= 1'b0;
            state <= (fidx == EB'(NE - 1)) ? S_FEND : S_FRD;
            fidx <= fidx + 1'b1;
          end
        end
        S_FEND: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (pend_v) begin
              out_data <= pend_end;
            end else begin
              out_data <= empty_rsp;
            end
            pend_v <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !pend_v)
    else $error("pending flush response while idle");

  assert property (@(posedge clk) disable iff (rst) (dirty & ~valid) == '0)
    else $error("dirty entry that is not valid");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> out_valid && out_data.last)
    else $error("access response not posted");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_VCHK) |-> !valid[{set, way}] || ram_rdata != tag)
    else $error("victim matches the missing tag");

endmodule

@@ tb/lru_cache_checker.sv @@
module lru_cache_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input lruc_pkg::req_t in_data,
  input logic out_valid,
  input logic out_ready,
  input lruc_pkg::rsp_t out_data,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [9:0] cfg_data,
  output int errors,
  output int pending
);

  localparam int WB = lruc_pkg::WAY_BITS;
  localparam int NS = lruc_pkg::NUM_SETS;
  localparam int NW = lruc_pkg::WAYS;
  localparam int OB = lruc_pkg::OFS_BITS;
  localparam int TB = lruc_pkg::TAG_BITS;

  logic [5:0] addr_width;
  logic [9:0] hit_cost, fill_cost, wb_cost;
  logic [TB-1:0] tags [NS][NW];
  logic line_valid [NS][NW];
  logic line_dirty [NS][NW];
  logic [WB-1:0] age_order [NS][NW];
  lruc_pkg::rsp_t expected_rsps [$];
  int error_count = 0;

  assign pending = expected_rsps.size();
  assign errors = error_count;

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [9:0] b);
    logic [16:0] s;
    s = a + b;
    return s > 17'hFFFF ? 16'hFFFF : s[15:0];
  endfunction

  task automatic predict_request(lruc_pkg::req_t req);
    lruc_pkg::rsp_t r;
    logic [31:0] mask, addr;
    logic [3:0] set;
    logic [TB-1:0] tag;
    logic [1:0] way;
    logic found;
    int pos, width, count;
    r = '0;
    if (req.operation == lruc_pkg::OP_FLUSH) begin
      count = 0;
      for (int s = 0; s < NS; s++)
        for (int w = 0; w < NW; w++)
          if (line_valid[s][w] && line_dirty[s][w]) begin
            line_dirty[s][w] = 1'b0;
            r.set_index = 4'(s);
            r.way_used = 2'(w);
            r.writeback_needed = 1'b1;
            r.writeback_address = {tags[s][w], 4'(s), {OB{1'b0}}};
            r.elapsed = sat_add(r.elapsed, wb_cost);
            expected_rsps = {expected_rsps, r};
            count++;
          end
      if (count == 0) expected_rsps = {expected_rsps, r};
      expected_rsps[$].last = 1'b1;
    end else if (req.operation != lruc_pkg::OP_UNUSED) begin
      width = addr_width > 32 ? 32 : addr_width;
      mask = width >= 32 ? 32'hFFFF_FFFF : 32'((64'd1 << width) - 1);
      addr = req.address & mask;
      set = addr[OB +: lruc_pkg::IDX_BITS];
      tag = addr[31 -: TB];
      found = 1'b0;
      way = '0;
      for (int w = NW - 1; w >= 0; w--)
        if (line_valid[set][w] && tags[set][w] == tag) begin
          found = 1'b1;
          way = 2'(w);
        end
      if (!found) begin
        r.elapsed = sat_add(r.elapsed, fill_cost);
        r.fill_needed = 1'b1;
        r.fill_address = {addr[31:OB], {OB{1'b0}}};
        way = age_order[set][0];
        if (line_valid[set][way] && line_dirty[set][way]) begin
          r.writeback_needed = 1'b1;
          r.writeback_address = {tags[set][way], set, {OB{1'b0}}};
          r.elapsed = sat_add(r.elapsed, wb_cost);
        end
        tags[set][way] = tag;
        line_valid[set][way] = 1'b1;
        line_dirty[set][way] = 1'b0;
      end
      r.elapsed = sat_add(r.elapsed, hit_cost);
      pos = 0;
      for (int i = 0; i < NW; i++)
        if (age_order[set][i] == way) pos = i;
      for (int i = pos; i < NW - 1; i++) age_order[set][i] = age_order[set][i + 1];
      age_order[set][NW - 1] = way;
      if (req.operation == lruc_pkg::OP_WRITE) line_dirty[set][way] = 1'b1;
      r.hit = found;
      r.set_index = set;
      r.way_used = way;
      r.last = 1'b1;
      expected_rsps = {expected_rsps, r};
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      addr_width = 6'd32;
      hit_cost = 10'd1;
      fill_cost = 10'd10;
      wb_cost = 10'd10;
      for (int s = 0; s < NS; s++)
        for (int w = 0; w < NW; w++) begin
          line_valid[s][w] = 1'b0;
          line_dirty[s][w] = 1'b0;
          age_order[s][w] = WB'(w);
        end
    end else begin
      if (cfg_we)
        case (cfg_index)
          lruc_pkg::REG_ADDRESS_BITS: addr_width = cfg_data[5:0];
          lruc_pkg::REG_HIT_CYCLES: hit_cost = cfg_data;
          lruc_pkg::REG_FILL_CYCLES: fill_cost = cfg_data;
          lruc_pkg::REG_WRITEBACK_CYCLES: wb_cost = cfg_data;
          default: ;
        endcase
      if (in_valid && in_ready) predict_request(in_data);
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response expected none actual %h", $time, out_data);
          error_count++;
        end else begin
          lruc_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          check_field("hit", e.hit, out_data.hit);
          check_field("set_index", e.set_index, out_data.set_index);
          check_field("way_used", e.way_used, out_data.way_used);
          check_field("fill_needed", e.fill_needed, out_data.fill_needed);
          check_field("fill_address", e.fill_address, out_data.fill_address);
          check_field("writeback_needed", e.writeback_needed, out_data.writeback_needed);
          check_field("writeback_address", e.writeback_address,
                      out_data.writeback_address);
          check_field("elapsed", e.elapsed, out_data.elapsed);
          check_field("last", e.last, out_data.last);
        end
      end
    end
  end

endmodule

@@ tb/lru_write_back_cache_controller_test.sv @@
module lru_write_back_cache_controller_test;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  lruc_pkg::req_t in_data;
  lruc_pkg::rsp_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;
  logic quiet;
  int errors, pending;
  logic [23:0] hot_tags [6];

  lru_write_back_cache_controller dut (.*);
  lru_cache_checker monitor (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  task automatic send(logic [1:0] op, logic [31:0] addr);
    in_valid <= 1'b1;
    in_data <= '{operation: op, address: addr};
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_requests(int n);
    logic [1:0] op;
    logic [31:0] addr;
    for (int i = 0; i < 6; i++) hot_tags[i] = 24'($urandom);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19)) inside
        0, 1: op = lruc_pkg::OP_FLUSH;
        2: op = lruc_pkg::OP_UNUSED;
        [3:11]: op = lruc_pkg::OP_READ;
        default: op = lruc_pkg::OP_WRITE;
      endcase
      addr = $urandom;
      if ($urandom_range(0, 9) < 7)
        addr = {hot_tags[$urandom_range(0, 5)], 4'($urandom_range(0, 3)), addr[3:0]};
      send(op, addr);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(lruc_pkg::OP_READ, 32'h0000_0000);
    send(lruc_pkg::OP_WRITE, 32'h0000_0004);
    send(lruc_pkg::OP_READ, 32'hFFFF_FFFF);
    send(lruc_pkg::OP_WRITE, 32'hFFFF_FFF0);
    for (int i = 1; i <= 5; i++) send(lruc_pkg::OP_WRITE, {24'(i), 4'h5, 4'h8});
    send(lruc_pkg::OP_READ, 32'h0000_0158);
    send(lruc_pkg::OP_UNUSED, 32'hA5A5_A5A5);
    send(lruc_pkg::OP_FLUSH, 32'h1234_5678);
    send(lruc_pkg::OP_FLUSH, 32'h0);
    drain;

    write_reg(lruc_pkg::REG_ADDRESS_BITS, 10'd8);
    write_reg(lruc_pkg::REG_HIT_CYCLES, 10'd0);
    write_reg(lruc_pkg::REG_FILL_CYCLES, 10'd0);
    write_reg(lruc_pkg::REG_WRITEBACK_CYCLES, 10'd0);
    send(lruc_pkg::OP_WRITE, 32'hFFFF_FF7C);
    send(lruc_pkg::OP_WRITE, 32'h1234_5670);
    send(lruc_pkg::OP_READ, 32'h0000_0070);
    send(lruc_pkg::OP_FLUSH, 32'h0);
    random_requests(60);
    drain;

    write_reg(lruc_pkg::REG_ADDRESS_BITS, 10'd63);
    write_reg(lruc_pkg::REG_HIT_CYCLES, 10'd1023);
    write_reg(lruc_pkg::REG_FILL_CYCLES, 10'd1023);
    write_reg(lruc_pkg::REG_WRITEBACK_CYCLES, 10'd1023);
    for (int i = 0; i < 64; i++) send(lruc_pkg::OP_WRITE, {24'(i * 7 + 1), 4'(i), 4'h0});
    send(lruc_pkg::OP_FLUSH, 32'h0);
    random_requests(90);
    drain;

    write_reg(lruc_pkg::REG_ADDRESS_BITS, 10'd12);
    write_reg(lruc_pkg::REG_HIT_CYCLES, 10'($urandom));
    write_reg(lruc_pkg::REG_FILL_CYCLES, 10'($urandom));
    write_reg(lruc_pkg::REG_WRITEBACK_CYCLES, 10'($urandom));
    random_requests(90);
    drain;

    write_reg(lruc_pkg::REG_ADDRESS_BITS, 10'd32);
    write_reg(lruc_pkg::REG_HIT_CYCLES, 10'd1);
    write_reg(lruc_pkg::REG_FILL_CYCLES, 10'd10);
    write_reg(lruc_pkg::REG_WRITEBACK_CYCLES, 10'd10);
    random_requests(100);
    quiet = 1'b1;
    random_requests(40);
    drain;

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
